// ----- rtl/color_ramp_interpolator_macros.svh -----
// Assertion helpers for the color ramp block.
`ifndef COLOR_RAMP_INTERPOLATOR_MACROS_SVH
`define COLOR_RAMP_INTERPOLATOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define CRI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("color ramp assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define CRI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("color ramp assertion failed");
`else
`define CRI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CRI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/cri_pkg.sv -----
package cri_pkg;

    localparam int POS_W          = 16;
    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = POS_W + NUM_CHAN * CHAN_W;
    localparam int STOP_COUNT_W   = 3;

    localparam int DEF_MAX_STOPS     = 7;
    localparam int DEF_FRACTION_BITS = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_FIRST = 3'd1;

    localparam logic [STOP_COUNT_W-1:0] STOP_COUNT_RESET = 3'd1;

    // Channel 0 is red, 1 green, 2 blue
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] t_color;

    typedef struct packed {
        t_color             color;
        logic [POS_W-1:0]   pos;
    } t_stop;

endpackage

// ----- rtl/color_ramp_interpolator.sv -----
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_sample_value (signed Q8.8)
// out      output     o_out_valid / i_out_ready o_red, o_green, o_blue
// cfg      input      i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// One word enters per cycle while o_in_ready is high; the restoring divider
// resolves one fraction bit per stage.
// Stage 0 picks the interval, stages 1..FRACTION_BITS divide, then multiply, then add.
// Synchronous active-low reset empties the pipeline and restores the stop registers.
// A stall at the output fills bubbles first; each stage holds only when the one after is full.
`include "color_ramp_interpolator_macros.svh"

module color_ramp_interpolator #(
    parameter int MAX_STOPS     = cri_pkg::DEF_MAX_STOPS,
    parameter int FRACTION_BITS = cri_pkg::DEF_FRACTION_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cri_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cri_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [cri_pkg::POS_W-1:0]   i_sample_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [cri_pkg::CHAN_W-1:0]         o_red,
    output logic [cri_pkg::CHAN_W-1:0]         o_green,
    output logic [cri_pkg::CHAN_W-1:0]         o_blue
);

    localparam int FB     = FRACTION_BITS;
    localparam int NS     = FB + 3;
    localparam int PW_    = cri_pkg::POS_W;
    localparam int CW     = cri_pkg::CHAN_W;
    localparam int NC     = cri_pkg::NUM_CHAN;
    localparam int DW     = CW + 1;
    localparam int PRW    = DW + FB + 1;
    localparam int SW     = CW + 2;
    localparam int NW     = $clog2(MAX_STOPS + 1);

    // configuration
    logic [cri_pkg::STOP_COUNT_W-1:0] r_stop_count;
    cri_pkg::t_stop                   r_stop [MAX_STOPS];

    // pipeline valids and load enables
    logic             r_vld  [NS];
    logic             s_load [NS];

    // divider stages 0..FB
    logic [PW_-1:0]         r_rem  [FB+1];
    logic [PW_-1:0]         r_span [FB+1];
    logic [FB-1:0]          r_q    [FB+1];
    cri_pkg::t_color        r_a    [FB+2];
    logic signed [DW-1:0]   r_d    [FB+1][NC];

    // multiply stage and output stage
    logic signed [PRW-1:0]  r_prod [NC];
    cri_pkg::t_color        r_out;

    // next values
    logic [PW_-1:0]         n_rem_in;
    logic [PW_-1:0]         n_rem  [1:FB];
    logic [PW_-1:0]         n_span;
    logic [FB-1:0]          n_q    [1:FB];
    cri_pkg::t_color        n_a;
    logic signed [DW-1:0]   n_d    [NC];
    logic signed [PRW-1:0]  n_prod [NC];
    cri_pkg::t_color        n_out;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= cri_pkg::STOP_COUNT_RESET;
            for (int i = 0; i < MAX_STOPS; i++) begin
                r_stop[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cri_pkg::REG_STOP_COUNT) begin
                r_stop_count <= i_cfg_data[cri_pkg::STOP_COUNT_W-1:0];
            end
            for (int i = 0; i < MAX_STOPS; i++) begin
                if (i_cfg_idx == cri_pkg::REG_STOP_FIRST + cri_pkg::CFG_IDX_W'(i)) begin
                    r_stop[i] <= i_cfg_data;
                end
            end
        end
    end

    // ---------------- handshake ----------------
    always_comb begin
        s_load[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int j = NS - 2; j >= 0; j--) begin
            s_load[j] = !r_vld[j] || s_load[j+1];
        end
    end

    assign o_in_ready  = s_load[0];
    assign o_out_valid = r_vld[NS-1];
    assign o_red       = r_out[0];
    assign o_green     = r_out[1];
    assign o_blue      = r_out[2];

    // ---------------- stage 0: interval select ----------------
    always_comb begin
        logic [NW-1:0]          s_n;
        logic                   s_hit;
        logic                   s_direct;
        logic signed [PW_-1:0]  s_low  [MAX_STOPS];
        cri_pkg::t_stop         s_prv  [MAX_STOPS];
        cri_pkg::t_stop         s_selp;
        cri_pkg::t_stop         s_selc;
        cri_pkg::t_stop         s_last;
        logic signed [PW_:0]    s_num;
        logic signed [PW_:0]    s_spn;

        // zero count acts as one stop, large counts saturate
        if (r_stop_count == '0) begin
            s_n = NW'(1);
        end else if (int'(r_stop_count) > MAX_STOPS) begin
            s_n = NW'(MAX_STOPS);
        end else begin
            s_n = NW'(r_stop_count);
        end

        s_low[0] = '0;
        s_prv[0] = r_stop[0];
        for (int i = 1; i < MAX_STOPS; i++) begin
            s_low[i] = signed'(r_stop[i-1].pos);
            s_prv[i] = r_stop[i-1];
        end

        s_last = r_stop[0];
        for (int i = 0; i < MAX_STOPS; i++) begin
            if (i == int'(s_n) - 1) begin
                s_last = r_stop[i];
            end
        end

        // scan starts at zero: negative samples fall through to the last stop
        s_hit    = 1'b0;
        s_direct = 1'b1;
        s_selp   = s_last;
        s_selc   = s_last;
        for (int i = 0; i < MAX_STOPS; i++) begin
            if (!s_hit && (i < int'(s_n)) && (i_sample_value >= s_low[i])
                    && (i_sample_value < signed'(r_stop[i].pos))) begin
                s_hit    = 1'b1;
                s_direct = (i == 0);
                s_selp   = s_prv[i];
                s_selc   = r_stop[i];
            end
        end

        s_num = (PW_+1)'(i_sample_value) - (PW_+1)'(signed'(s_selp.pos));
        s_spn = (PW_+1)'(signed'(s_selc.pos)) - (PW_+1)'(signed'(s_selp.pos));
        if (s_direct) begin
            n_rem_in = '0;
            n_span   = PW_'(1);
        end else begin
            n_rem_in = s_num[PW_-1:0];
            n_span   = s_spn[PW_-1:0];
        end
        n_a    = s_selp.color;
        for (int c = 0; c < NC; c++) begin
            // flat color on the direct path: zero delta
            if (s_direct) begin
                n_d[c] = '0;
            end else begin
                n_d[c] = signed'({1'b0, s_selc.color[c]}) - signed'({1'b0, s_selp.color[c]});
            end
        end
    end

    // ---------------- stages 1..FB: restoring divide ----------------
    always_comb begin
        logic [PW_:0] s_sh;
        logic         s_ge;
        for (int j = 1; j <= FB; j++) begin
            s_sh     = {r_rem[j-1], 1'b0};
            s_ge     = s_sh >= {1'b0, r_span[j-1]};
            n_rem[j] = s_ge ? PW_'(s_sh - {1'b0, r_span[j-1]}) : s_sh[PW_-1:0];
            n_q[j]   = {r_q[j-1][FB-2:0], s_ge};
        end
    end

    // ---------------- multiply and add ----------------
    always_comb begin
        logic signed [SW-1:0] s_sum;
        logic signed [PRW-1:0] s_shr;
        for (int c = 0; c < NC; c++) begin
            n_prod[c] = PRW'(r_d[FB][c]) * PRW'(signed'({1'b0, r_q[FB]}));
        end
        for (int c = 0; c < NC; c++) begin
            // arithmetic shift rounds toward minus infinity
            s_shr    = r_prod[c] >>> FB;
            s_sum    = signed'(SW'(r_a[FB+1][c])) + SW'(s_shr);
            n_out[c] = s_sum[CW-1:0];
        end
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NS; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            if (s_load[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int j = 1; j < NS; j++) begin
                if (s_load[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load[0]) begin
            r_rem[0]  <= n_rem_in;
            r_span[0] <= n_span;
            r_q[0]    <= '0;
            r_a[0]    <= n_a;
            for (int c = 0; c < NC; c++) begin
                r_d[0][c] <= n_d[c];
            end
        end
        for (int j = 1; j <= FB; j++) begin
            if (s_load[j]) begin
                r_rem[j]  <= n_rem[j];
                r_span[j] <= r_span[j-1];
                r_q[j]    <= n_q[j];
                r_a[j]    <= r_a[j-1];
                for (int c = 0; c < NC; c++) begin
                    r_d[j][c] <= r_d[j-1][c];
                end
            end
        end
        if (s_load[FB+1]) begin
            r_a[FB+1] <= r_a[FB];
            for (int c = 0; c < NC; c++) begin
                r_prod[c] <= n_prod[c];
            end
        end
        if (s_load[NS-1]) begin
            r_out <= n_out;
        end
    end

    // ---------------- assertions ----------------
    `CRI_ASSERT_IMP(a_sel_rem_below_span, i_clk, i_rst_n, r_vld[0], r_rem[0] < r_span[0])
    `CRI_ASSERT_IMP(a_div_rem_below_span, i_clk, i_rst_n, r_vld[FB], r_rem[FB] < r_span[FB])
    `CRI_ASSERT_IMP(a_stall_means_full, i_clk, i_rst_n, !o_in_ready, r_vld[0])
    `CRI_ASSERT_IMP(a_out_from_pipe, i_clk, i_rst_n, $rose(o_out_valid), $past(r_vld[NS-2]))
    `CRI_ASSERT_NXT(a_full_stall_holds, i_clk, i_rst_n, !o_in_ready, r_vld[NS-1])

endmodule
